@@ src/assert_macros.svh @@
// Assertion macros used by the ALU top level to check its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define ALU8F_ASSERT_IMPL(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define ALU8F_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

@@ src/alu8f_pkg.sv @@
// Package with the transaction types, opcodes and flag positions of the 8-bit ALU.
`default_nettype none

package alu8f_pkg;

	localparam logic [3:0] OP_ADD = 4'd0;
	localparam logic [3:0] OP_ADC = 4'd1;
	localparam logic [3:0] OP_SUB = 4'd2;
	localparam logic [3:0] OP_SBC = 4'd3;
	localparam logic [3:0] OP_AND = 4'd4;
	localparam logic [3:0] OP_XOR = 4'd5;
	localparam logic [3:0] OP_OR  = 4'd6;
	localparam logic [3:0] OP_CP  = 4'd7;
	localparam logic [3:0] OP_INC = 4'd8;
	localparam logic [3:0] OP_DEC = 4'd9;
	localparam logic [3:0] OP_RLC = 4'd10;
	localparam logic [3:0] OP_RL  = 4'd11;
	localparam logic [3:0] OP_RRC = 4'd12;
	localparam logic [3:0] OP_RR  = 4'd13;

	// Bit positions inside the flag nibble.
	localparam int FLAG_Z = 3;
	localparam int FLAG_N = 2;
	localparam int FLAG_H = 1;
	localparam int FLAG_C = 0;

	typedef struct packed {
		logic [3:0] op;
		logic [7:0] operand_a;
		logic [7:0] operand_b;
		logic [3:0] flags_in;
		logic       accumulator_form;
	} cmd_t;

	typedef struct packed {
		logic [7:0] result;
		logic [3:0] flags_out;
	} rsp_t;

endpackage

`default_nettype wire

@@ src/alu8f_core.sv @@
// Combinational datapath of the 8-bit ALU: result byte and new flag nibble.
`default_nettype none

module alu8f_core (
	input  alu8f_pkg::cmd_t cmd,
	output alu8f_pkg::rsp_t rsp
);

	logic [7:0] a;
	logic [7:0] b;
	logic       cin;
	logic       carry_used;
	logic [8:0] sum;
	logic [4:0] half_sum;
	logic [8:0] diff;
	logic [4:0] half_diff;
	logic [7:0] r;
	logic       z;
	logic       n;
	logic       h;
	logic       c;
	logic       rot_c;
	logic [7:0] rot_r;

	assign a   = cmd.operand_a;
	assign b   = cmd.operand_b;
	assign cin = cmd.flags_in[alu8f_pkg::FLAG_C];

	// Carry or borrow input only for the with-carry forms.
	assign carry_used = ((cmd.op == alu8f_pkg::OP_ADC) || (cmd.op == alu8f_pkg::OP_SBC)) ? cin
		: 1'b0;

	assign sum       = {1'b0, a} + {1'b0, b} + {8'd0, carry_used};
	assign half_sum  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, carry_used};
	// Bit 8 and bit 4 of the differences are the full and half borrows.
	assign diff      = {1'b0, a} - {1'b0, b} - {8'd0, carry_used};
	assign half_diff = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, carry_used};

	always_comb begin
		rot_c = a[7];
		rot_r = {a[6:0], a[7]};
		case (cmd.op)
			alu8f_pkg::OP_RL: begin
				rot_c = a[7];
				rot_r = {a[6:0], cin};
			end
			alu8f_pkg::OP_RRC: begin
				rot_c = a[0];
				rot_r = {a[0], a[7:1]};
			end
			alu8f_pkg::OP_RR: begin
				rot_c = a[0];
				rot_r = {cin, a[7:1]};
			end
			default: begin
				rot_c = a[7];
				rot_r = {a[6:0], a[7]};
			end
		endcase
	end

	always_comb begin
		r = a;
		z = cmd.flags_in[alu8f_pkg::FLAG_Z];
		n = cmd.flags_in[alu8f_pkg::FLAG_N];
		h = cmd.flags_in[alu8f_pkg::FLAG_H];
		c = cin;
		case (cmd.op)
			alu8f_pkg::OP_ADD, alu8f_pkg::OP_ADC: begin
				r = sum[7:0];
				z = (sum[7:0] == 8'd0);
				n = 1'b0;
				h = half_sum[4];
				c = sum[8];
			end
			alu8f_pkg::OP_SUB, alu8f_pkg::OP_SBC, alu8f_pkg::OP_CP: begin
				// Compare sets flags like subtract but leaves the byte alone.
				r = (cmd.op == alu8f_pkg::OP_CP) ? a : diff[7:0];
				z = (diff[7:0] == 8'd0);
				n = 1'b1;
				h = half_diff[4];
				c = diff[8];
			end
			alu8f_pkg::OP_AND: begin
				r = a & b;
				z = ((a & b) == 8'd0);
				n = 1'b0;
				h = 1'b1;
				c = 1'b0;
			end
			alu8f_pkg::OP_XOR: begin
				r = a ^ b;
				z = ((a ^ b) == 8'd0);
				n = 1'b0;
				h = 1'b0;
				c = 1'b0;
			end
			alu8f_pkg::OP_OR: begin
				r = a | b;
				z = ((a | b) == 8'd0);
				n = 1'b0;
				h = 1'b0;
				c = 1'b0;
			end
			alu8f_pkg::OP_INC: begin
				r = a + 8'd1;
				z = (a == 8'hFF);
				n = 1'b0;
				h = (a[3:0] == 4'hF);
			end
			alu8f_pkg::OP_DEC: begin
				r = a - 8'd1;
				z = (a == 8'd1);
				n = 1'b1;
				h = (a[3:0] == 4'h0);
			end
			alu8f_pkg::OP_RLC, alu8f_pkg::OP_RL, alu8f_pkg::OP_RRC, alu8f_pkg::OP_RR: begin
				r = rot_r;
				z = !cmd.accumulator_form && (rot_r == 8'd0);
				n = 1'b0;
				h = 1'b0;
				c = rot_c;
			end
			default: begin
				r = a;
				z = cmd.flags_in[alu8f_pkg::FLAG_Z];
				n = cmd.flags_in[alu8f_pkg::FLAG_N];
				h = cmd.flags_in[alu8f_pkg::FLAG_H];
				c = cin;
			end
		endcase
	end

	assign rsp.result    = r;
	assign rsp.flags_out = {z, n, h, c};

endmodule

`default_nettype wire

@@ src/alu_8bit_with_flags.sv @@
// Top level of the 8-bit ALU with flags: command register, datapath and result register.
`default_nettype none

// The ALU takes one command transaction per clock cycle and returns exactly one result
// transaction for each: a command accepted at one rising edge of clk is captured in the
// command register, passes the combinational datapath during the next cycle, and is then
// captured in the result register and shown on rsp with done high for a single cycle.
// The rate of one transaction per cycle is set by the single pass through the datapath
// between the command register and the result register. busy is never raised, so a
// command is accepted at every edge at which start is high. The receiver cannot stall:
// each result is present for exactly one cycle and must be taken then. Results leave in
// the same order as the commands came in. The block holds no state between transactions;
// reset only clears the two valid bits of the pipeline.
module alu_8bit_with_flags (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	output logic             busy,
	input  alu8f_pkg::cmd_t  cmd,
	output logic             done,
	output alu8f_pkg::rsp_t  rsp
);

	`include "assert_macros.svh"

	// Command register: one transaction in flight per stage.
	logic            valid_s1;
	alu8f_pkg::cmd_t cmd_s1;

	// Result register that drives the outputs.
	logic            done_s2;
	alu8f_pkg::rsp_t rsp_s2;

	alu8f_pkg::rsp_t rsp_comb;

	// The pipeline advances every cycle, so a new command is always welcome.
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_s2  <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			done_s2  <= valid_s1;
		end
	end

	// Payload registers carry no reset; the valid bits qualify them.
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1 <= cmd;
		end
		if (valid_s1) begin
			rsp_s2 <= rsp_comb;
		end
	end

	alu8f_core u_core (
		.cmd (cmd_s1),
		.rsp (rsp_comb)
	);

	assign done = done_s2;
	assign rsp  = rsp_s2;

	// Every command in the first stage leaves as a result in the next cycle.
	`ALU8F_ASSERT_NEXT(a_result_follows, valid_s1, done, "command without a result")

	// Compare must hand back operand_a unchanged.
	`ALU8F_ASSERT_NEXT(a_cp_keeps_a, valid_s1 && (cmd_s1.op == alu8f_pkg::OP_CP),
		rsp.result == $past(cmd_s1.operand_a), "compare changed the result byte")

	// Increment and decrement pass the incoming carry through.
	`ALU8F_ASSERT_NEXT(a_incdec_keep_c,
		valid_s1 && ((cmd_s1.op == alu8f_pkg::OP_INC) || (cmd_s1.op == alu8f_pkg::OP_DEC)),
		rsp.flags_out[alu8f_pkg::FLAG_C] == $past(cmd_s1.flags_in[alu8f_pkg::FLAG_C]),
		"inc or dec changed the carry flag")

	// A result strobe never appears without a command in the first stage in the cycle before.
	`ALU8F_ASSERT_IMPL(a_no_spurious_done, done, $past(valid_s1), "result without a command")

endmodule

`default_nettype wire
